FILE: src/rc4a85_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed stream cipher with ASCII85 armor.
package rc4a85_pkg;

   localparam int BYTE_W           = 8;
   localparam int SBOX_DEPTH       = 256;
   localparam int KEY_W            = 64;
   localparam int KEY_SEL_W        = 6;
   localparam int KEY_BITS_DEFAULT = 64;
   localparam int WORD_W           = 32;
   localparam int CHAR_W           = 7;
   localparam int DIGITS           = 5;
   localparam int DIGIT_CNT_W      = 3;
   localparam int GROUP_CNT_W      = 2;

   localparam logic [CHAR_W-1:0] A85_OFFSET = 7'd33;
   localparam logic [CHAR_W-1:0] A85_BASE   = 7'd85;

   // floor(w / 85) == (w * RECIP_85) >> RECIP_SHIFT for every 32-bit w.
   localparam logic [WORD_W-1:0] RECIP_85    = 32'hC0C0_C0C1;
   localparam int                RECIP_SHIFT = 38;
   localparam int                QUOT_W      = 2 * WORD_W - RECIP_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_DIV_MUL,
      ST_DIV_SUB,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic sched_init;
      logic fill_wr;
      logic rd_i;
      logic rd_j;
      logic wr_i;
      logic wr_j;
      logic sched;
      logic pad;
      logic div_mul;
      logic div_sub;
      logic out_load;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic i_last;
      logic grp_last;
      logic eom;
   } status_type;

endpackage

FILE: src/rc4a85_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rc4a85_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rc4a85_datapath.sv
`timescale 1ns / 1ps
// Datapath: S-box memory, swap indices, word packing, base-85 digit unit, output register.
module rc4a85_datapath #(
   parameter int KEY_BITS = rc4a85_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rc4a85_pkg::cmd_type               cmd,
   output rc4a85_pkg::status_type            status,
   input  logic [rc4a85_pkg::BYTE_W-1:0]     req_plain_byte,
   input  logic                              req_end_of_message,
   input  logic                              csr_write_enable,
   input  logic [rc4a85_pkg::KEY_W-1:0]      csr_write_data,
   output logic [rc4a85_pkg::CHAR_W-1:0]     rsp_armor_char,
   output logic                              rsp_last_char
);
   import rc4a85_pkg::*;

   localparam int KIDX_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BITS - 1);

   logic [KEY_W-1:0]        key_ff;
   logic [BYTE_W-1:0]       plain_ff;
   logic                    eom_ff;
   logic [BYTE_W-1:0]       i_ff, i_in;
   logic [BYTE_W-1:0]       j_ff, j_in;
   logic [BYTE_W-1:0]       si_ff, sj_ff, t_ff;
   logic [KIDX_W-1:0]       kidx_ff;
   logic [GROUP_CNT_W-1:0]  grp_ff;
   logic [WORD_W-1:0]       word_ff;
   logic [2*WORD_W-1:0]     prod_ff;
   logic [CHAR_W-1:0]       dig_ff [DIGITS];
   logic [CHAR_W-1:0]       char_ff;
   logic                    last_ff;

   logic                    ram_we;
   logic [BYTE_W-1:0]       ram_waddr, ram_wdata, ram_raddr, ram_rdata;
   logic                    key_bit;
   logic [BYTE_W-1:0]       ks_byte, enc_byte;
   logic [QUOT_W-1:0]       quot;
   logic [WORD_W-1:0]       rem_full;

   rc4a85_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SBOX_DEPTH)
   ) u_sbox (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign key_bit = key_ff[KEY_SEL_W'(kidx_ff)];

   // The swap may touch the entry read for the keystream, so forward it.
   always_comb begin
      priority if (t_ff == i_ff) begin
         ks_byte = sj_ff;
      end else if (t_ff == j_ff) begin
         ks_byte = si_ff;
      end else begin
         ks_byte = ram_rdata;
      end
   end

   assign enc_byte = cmd.pad ? ks_byte : (plain_ff ^ ks_byte);
   assign quot     = prod_ff[2*WORD_W-1:RECIP_SHIFT];
   assign rem_full = word_ff - (WORD_W'(quot) * WORD_W'(A85_BASE));

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = i_ff;
      ram_wdata = i_ff;
      ram_raddr = i_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      if (cmd.fill_wr) begin
         ram_we = 1'b1;
         i_in   = i_ff + 8'd1;
      end
      if (cmd.rd_i && !cmd.sched) begin
         i_in      = i_ff + 8'd1;
         ram_raddr = i_ff + 8'd1;
      end
      if (cmd.rd_j) begin
         j_in      = BYTE_W'(j_ff + ram_rdata + {7'd0, cmd.sched & key_bit});
         ram_raddr = j_in;
      end
      if (cmd.wr_i) begin
         ram_we    = 1'b1;
         ram_waddr = i_ff;
         ram_wdata = ram_rdata;
         ram_raddr = BYTE_W'(si_ff + ram_rdata);
      end
      if (cmd.wr_j) begin
         ram_we    = 1'b1;
         ram_waddr = j_ff;
         ram_wdata = si_ff;
         if (cmd.sched) begin
            i_in = i_ff + 8'd1;
         end
      end
      if (cmd.sched_init) begin
         i_in = '0;
         j_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
         kidx_ff <= '0;
         grp_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            key_ff <= csr_write_data;
         end
         i_ff <= i_in;
         j_ff <= j_in;
         if (cmd.sched_init) begin
            kidx_ff <= '0;
            grp_ff  <= '0;
         end else if (cmd.wr_j && cmd.sched) begin
            kidx_ff <= (kidx_ff == KIDX_LAST) ? '0 : kidx_ff + 1'b1;
         end else if (cmd.wr_j) begin
            grp_ff <= grp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         plain_ff <= req_plain_byte;
         eom_ff   <= req_end_of_message;
      end
      if (cmd.rd_j) begin
         si_ff <= ram_rdata;
      end
      if (cmd.wr_i) begin
         sj_ff <= ram_rdata;
         t_ff  <= BYTE_W'(si_ff + ram_rdata);
      end
      if (cmd.wr_j && !cmd.sched) begin
         word_ff <= {word_ff[WORD_W-BYTE_W-1:0], enc_byte};
      end
      if (cmd.div_mul) begin
         prod_ff <= word_ff * RECIP_85;
      end
      if (cmd.div_sub) begin
         word_ff   <= WORD_W'(quot);
         dig_ff[0] <= rem_full[CHAR_W-1:0];
         for (int k = 1; k < DIGITS; k++) begin
            dig_ff[k] <= dig_ff[k-1];
         end
      end
      // Digits were pushed least significant first, so slot 0 holds the leading one.
      if (cmd.out_load) begin
         char_ff <= dig_ff[0] + A85_OFFSET;
         last_ff <= cmd.out_last;
         for (int k = 0; k < DIGITS - 1; k++) begin
            dig_ff[k] <= dig_ff[k+1];
         end
      end
   end

   assign status.i_last   = (i_ff == 8'hFF);
   assign status.grp_last = (grp_ff == 2'd3);
   assign status.eom      = eom_ff;

   assign rsp_armor_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

FILE: src/rc4a85_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences fill, key schedule, keystream, conversion and output.
module rc4a85_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rc4a85_pkg::status_type  status,
   output rc4a85_pkg::cmd_type     cmd
);
   import rc4a85_pkg::*;

   localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST = DIGIT_CNT_W'(DIGITS - 1);

   state_type               state_ff, state_in;
   logic                    in_msg_ff, in_msg_in;
   logic                    sched_ff, sched_in;
   logic                    pad_ff, pad_in;
   logic                    valid_ff, valid_in;
   logic [DIGIT_CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_msg_ff <= 1'b0;
         sched_ff  <= 1'b0;
         pad_ff    <= 1'b0;
         valid_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         in_msg_ff <= in_msg_in;
         sched_ff  <= sched_in;
         pad_ff    <= pad_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      in_msg_in = in_msg_ff;
      sched_in  = sched_ff;
      pad_in    = pad_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff & ~rsp_ready;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sched = sched_ff;
      cmd.pad   = pad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               pad_in      = 1'b0;
               if (!in_msg_ff) begin
                  cmd.sched_init = 1'b1;
                  sched_in       = 1'b1;
                  state_in       = ST_FILL;
               end else begin
                  state_in = ST_RD_I;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (status.i_last) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: begin
            cmd.rd_i = 1'b1;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            cmd.rd_j = 1'b1;
            state_in = ST_WR_I;
         end
         ST_WR_I: begin
            cmd.wr_i = 1'b1;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            cmd.wr_j = 1'b1;
            if (sched_ff) begin
               // Schedule ends with i wrapped back to zero; j carries over.
               if (status.i_last) begin
                  sched_in  = 1'b0;
                  in_msg_in = 1'b1;
               end
               state_in = ST_RD_I;
            end else if (status.grp_last) begin
               cnt_in = '0;
               if (status.eom) begin
                  in_msg_in = 1'b0;
               end
               state_in = ST_DIV_MUL;
            end else if (status.eom) begin
               // Pad the final group with bare keystream bytes.
               pad_in   = 1'b1;
               state_in = ST_RD_I;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_DIV_SUB;
         end
         ST_DIV_SUB: begin
            cmd.div_sub = 1'b1;
            if (cnt_ff == DIGIT_LAST) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_DIV_MUL;
            end
         end
         ST_EMIT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_last = status.eom && (cnt_ff == DIGIT_LAST);
               valid_in     = 1'b1;
               if (cnt_ff == DIGIT_LAST) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

FILE: src/rc4_variant_ascii85_encrypt.sv
`timescale 1ns / 1ps
// Top level: keyed stream cipher over a 256-entry S-box with ASCII85 armored output.
//
// Each plaintext byte is taken in the idle state and then goes through the S-box
// memory steps read S[i], read S[j], write S[i] with keystream read and write S[j].
// The first byte of a message first fills the S-box and runs the key schedule,
// whose steps use the same memory sequence. A completed group of four bytes then
// goes through base-85 conversion (multiply and subtract per digit) and hands out
// its characters, waiting under backpressure; each pad byte of the final group runs
// the memory steps without a new byte being taken. A new key written on the csr port
// takes effect at the next key schedule, and the character register lets the next
// byte be accepted while the last character of a group still waits for its transfer.
module rc4_variant_ascii85_encrypt #(
   parameter int KEY_BITS = rc4a85_pkg::KEY_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rc4a85_pkg::BYTE_W-1:0]   req_plain_byte,
   input  logic                            req_end_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rc4a85_pkg::CHAR_W-1:0]   rsp_armor_char,
   output logic                            rsp_last_char,
   input  logic                            csr_write_enable,
   input  logic [rc4a85_pkg::KEY_W-1:0]    csr_write_data
);
   import rc4a85_pkg::*;

   cmd_type    cmd;
   status_type status;

   rc4a85_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rc4a85_datapath #(
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_plain_byte     (req_plain_byte),
      .req_end_of_message (req_end_of_message),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_armor_char     (rsp_armor_char),
      .rsp_last_char      (rsp_last_char)
   );

endmodule
